// ----- hw/rtl/mva_pkg.sv -----
// mva_pkg: shared constants and types of the motor voice allocator
// no dependencies; used by the channel interfaces and the top level

package mva_pkg;

  // number of voices in the voice table (range 1 to 4, as the voice field is VoiceW = 2 bits wide)
  localparam int unsigned NumVoices = 4;
  localparam int unsigned VoiceIdxW = (NumVoices > 1) ? $clog2(NumVoices) : 1;

  // fixed field widths of the requests and results
  localparam int unsigned ToneW  = 7;
  localparam int unsigned VoiceW = 2;

  typedef logic [ToneW-1:0]     tone_t;
  typedef logic [VoiceW-1:0]    voice_t;
  typedef logic [VoiceIdxW-1:0] vidx_t;

endpackage

// ----- hw/rtl/mva_if.sv -----
// mva_note_if and mva_result_if: valid/ready channels of the voice allocator
// depends on mva_pkg for field types

interface mva_note_if;
  logic           valid;
  logic           ready;
  logic           is_press;
  mva_pkg::tone_t tone;

  modport source (output valid, output is_press, output tone, input ready);
  modport sink   (input valid, input is_press, input tone, output ready);
endinterface

interface mva_result_if;
  logic            valid;
  logic            ready;
  logic            accepted;
  mva_pkg::voice_t voice;
  logic            running;
  mva_pkg::tone_t  tone_out;

  modport source (output valid, output accepted, output voice, output running,
                  output tone_out, input ready);
  modport sink   (input valid, input accepted, input voice, input running,
                  input tone_out, output ready);
endinterface

// ----- hw/rtl/motor_voice_allocator_unit.sv -----
// motor_voice_allocator_unit: an accepted note request reaches its result on the output channel
// through the input register, then lookup and result register
// throughput is one request per cycle while the output register is not stalled; the voice table is searched in parallel
// the output register stalls the input register only when a result is held
// reset (rst_ni low, asynchronous) frees every voice with tone 0 and empties both stages
// depends on mva_pkg and mva_if

module motor_voice_allocator_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  mva_note_if.sink            note_i,
  mva_result_if.source        result_o
);

  // ---------------------------------------------------------------------------
  // pipeline control
  // ---------------------------------------------------------------------------
  logic           in_valid_q;
  logic           in_press_q;
  mva_pkg::tone_t in_tone_q;

  logic           out_valid_q;
  logic           out_accepted_q;
  mva_pkg::voice_t out_voice_q;
  logic           out_running_q;
  mva_pkg::tone_t out_tone_q;

  logic advance;   // result register can take a new value
  logic process;   // request in the input register is handled this cycle
  logic in_ready;

  assign advance  = !out_valid_q || result_o.ready;
  assign process  = in_valid_q && advance;
  assign in_ready = !in_valid_q || advance;

  assign note_i.ready = in_ready;

  // input register: valid bit reset, payload plain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= note_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (note_i.valid && in_ready) begin
      in_press_q <= note_i.is_press;
      in_tone_q  <= note_i.tone;
    end
  end

  // ---------------------------------------------------------------------------
  // voice table
  // ---------------------------------------------------------------------------
  logic [mva_pkg::NumVoices-1:0] voice_running_q;
  mva_pkg::tone_t                voice_tone_q [mva_pkg::NumVoices];

  // lowest free voice for a press, lowest running voice holding the tone for a release
  logic          free_hit;
  mva_pkg::vidx_t free_idx;
  logic          rel_hit;
  mva_pkg::vidx_t rel_idx;

  always_comb begin
    free_hit = 1'b0;
    free_idx = '0;
    rel_hit  = 1'b0;
    rel_idx  = '0;
    // descending scan so the lowest index wins
    for (int i = mva_pkg::NumVoices - 1; i >= 0; i--) begin
      if (!voice_running_q[i]) begin
        free_hit = 1'b1;
        free_idx = mva_pkg::vidx_t'(i);
      end
      // only running voices match, so a release of tone 0 never hits a free voice
      if (voice_running_q[i] && (voice_tone_q[i] == in_tone_q)) begin
        rel_hit = 1'b1;
        rel_idx = mva_pkg::vidx_t'(i);
      end
    end
  end

  logic           hit;
  mva_pkg::vidx_t sel_idx;
  logic [mva_pkg::VoiceIdxW+mva_pkg::VoiceW-1:0] sel_idx_ext;

  assign hit         = in_press_q ? free_hit : rel_hit;
  assign sel_idx     = in_press_q ? free_idx : rel_idx;
  // voice field carries the index masked to its width
  assign sel_idx_ext = {{mva_pkg::VoiceW{1'b0}}, sel_idx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_running_q <= '0;
      for (int i = 0; i < mva_pkg::NumVoices; i++) begin
        voice_tone_q[i] <= '0;
      end
    end else if (process && hit) begin
      voice_running_q[sel_idx] <= in_press_q;
      voice_tone_q[sel_idx]    <= in_press_q ? in_tone_q : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      out_accepted_q <= hit;
      out_voice_q    <= hit ? sel_idx_ext[mva_pkg::VoiceW-1:0] : '0;
      out_running_q  <= hit && in_press_q;
      out_tone_q     <= (hit && in_press_q) ? in_tone_q : '0;
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.accepted = out_accepted_q;
  assign result_o.voice    = out_voice_q;
  assign result_o.running  = out_running_q;
  assign result_o.tone_out = out_tone_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // a refused request reports all-zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_accepted_q) |->
      (out_voice_q == '0) && !out_running_q && (out_tone_q == '0))
    else $error("refused result carries nonzero fields");

  // a successful press claims exactly one more voice
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && in_press_q && free_hit) |=>
      ($countones(voice_running_q) == $past($countones(voice_running_q)) + 1))
    else $error("press did not claim exactly one voice");

  // a successful release stops the matched voice and clears its tone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && !in_press_q && rel_hit) |=>
      (!voice_running_q[$past(rel_idx)] && (voice_tone_q[$past(rel_idx)] == '0)))
    else $error("release left the matched voice running");

  // a stopped voice result never reports a tone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_running_q) |-> (out_tone_q == '0))
    else $error("stopped voice reports a tone");

endmodule

// ----- verif/voice_alloc_sb_pkg.sv -----
`timescale 1ns / 100ps
// voice_alloc_sb_pkg: result record and scoreboard class for the voice allocator bench
// depends on mva_pkg for the voice count and the request and result field types

package voice_alloc_sb_pkg;
  import mva_pkg::*;

  typedef struct packed {
    logic   accepted;
    voice_t voice;
    logic   running;
    tone_t  tone_out;
  } alloc_result_t;

  class voice_alloc_scoreboard;
    logic          voice_busy[NumVoices];
    tone_t         voice_tone[NumVoices];
    alloc_result_t alloc_due_q[$];
    int unsigned   mismatches = 0;

    function void clear_voices();
      for (int unsigned i = 0; i < NumVoices; i++) begin
        voice_busy[i] = 1'b0;
        voice_tone[i] = '0;
      end
      alloc_due_q.delete();
    endfunction

    // first free voice on a press, first running voice with the tone on a release
    function void log_note(logic is_press, tone_t tone);
      alloc_result_t res;
      bit            done;
      res  = '0;
      done = 1'b0;
      for (int unsigned i = 0; i < NumVoices && !done; i++) begin
        if (is_press && !voice_busy[i]) begin
          voice_busy[i] = 1'b1;
          voice_tone[i] = tone;
          res           = '{accepted: 1'b1, voice: voice_t'(i), running: 1'b1, tone_out: tone};
          done          = 1'b1;
        end else if (!is_press && voice_busy[i] && voice_tone[i] == tone) begin
          voice_busy[i] = 1'b0;
          voice_tone[i] = '0;
          res           = '{accepted: 1'b1, voice: voice_t'(i), running: 1'b0, tone_out: '0};
          done          = 1'b1;
        end
      end
      alloc_due_q.push_back(res);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_alloc(alloc_result_t got);
      alloc_result_t want;
      if (alloc_due_q.size() == 0) begin
        $display("%0t: result with none expected, actual %p", $time, got);
        mismatches++;
        return;
      end
      want = alloc_due_q.pop_front();
      cmp_field("accepted", 32'(want.accepted), 32'(got.accepted));
      cmp_field("voice", 32'(want.voice), 32'(got.voice));
      cmp_field("running", 32'(want.running), 32'(got.running));
      cmp_field("tone_out", 32'(want.tone_out), 32'(got.tone_out));
    endfunction

    function int unsigned pending();
      return alloc_due_q.size();
    endfunction

    function int unsigned busy_count();
      int unsigned n;
      n = 0;
      for (int unsigned i = 0; i < NumVoices; i++) n += 32'(voice_busy[i]);
      return n;
    endfunction

    // tone of a randomly chosen running voice, 0 if none runs
    function tone_t held_tone();
      tone_t held_q[$];
      for (int unsigned i = 0; i < NumVoices; i++)
        if (voice_busy[i]) held_q.push_back(voice_tone[i]);
      if (held_q.size() == 0) return '0;
      return held_q[$urandom_range(held_q.size() - 1)];
    endfunction
  endclass

endpackage

// ----- verif/motor_voice_allocator_unit_test.sv -----
`timescale 1ns / 100ps
// motor_voice_allocator_unit_test: directed and random note requests against a voice table model
// depends on mva_pkg, mva_if, voice_alloc_sb_pkg and the motor_voice_allocator_unit rtl

module motor_voice_allocator_unit_test;
  import mva_pkg::*;
  import voice_alloc_sb_pkg::*;

  localparam real         ClkPeriod    = 10.0;
  localparam int unsigned ResetCycles  = 12;
  localparam int unsigned PhaseItems   = 100;
  localparam int unsigned LongHold     = 60;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned CycleLimit   = 200000;

  // values of the is_press field
  localparam logic NotePress   = 1'b1;
  localparam logic NoteRelease = 1'b0;

  logic clk = 1'b0;
  logic rst_n;

  mva_note_if   note_ch ();
  mva_result_if alloc_ch ();

  motor_voice_allocator_unit u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .note_i  (note_ch),
    .result_o(alloc_ch)
  );

  voice_alloc_scoreboard sb = new();

  // idling chances in percent, set per phase by the main sequence
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  // long receiver hold-off: main bumps hold_ask, receiver counts the hold itself
  int unsigned hold_ask;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned cycles;

  always #(ClkPeriod / 2.0) clk = ~clk;

  // result side: check what was taken at this edge, then pick ready for the next one
  always @(posedge clk) begin
    if (rst_n) begin
      if (alloc_ch.valid && alloc_ch.ready)
        sb.check_alloc({alloc_ch.accepted, alloc_ch.voice, alloc_ch.running, alloc_ch.tone_out});
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        alloc_ch.ready <= 1'b0;
      end else begin
        alloc_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("** motor_voice_allocator_unit: FAILED **");
      $finish;
    end
  end

  // offer one note request, with random idle cycles ahead of it, and log it once taken
  task automatic send_note(logic is_press, tone_t tone);
    while ($urandom_range(99) < send_idle_pct) begin
      note_ch.valid <= 1'b0;
      @(posedge clk);
    end
    note_ch.valid    <= 1'b1;
    note_ch.is_press <= is_press;
    note_ch.tone     <= tone;
    @(posedge clk);
    while (!note_ch.ready) @(posedge clk);
    sb.log_note(is_press, tone);
  endtask

  // sender pauses until every expected result is back
  task automatic drain_allocs();
    note_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // mostly presses and releases of held tones, some releases of random tones that may match nothing
  task automatic random_notes(int unsigned count);
    int unsigned pick;
    tone_t       tone;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        // a narrow tone band makes duplicate tones across voices common
        case ($urandom_range(3))
          0:       tone = tone_t'($urandom_range(63, 60));
          1:       tone = $urandom_range(1) ? 7'h7f : 7'h00;
          default: tone = tone_t'($urandom_range(127));
        endcase
        send_note(NotePress, tone);
      end else if (pick < 85 && sb.busy_count() > 0) begin
        send_note(NoteRelease, sb.held_tone());
      end else begin
        tone = $urandom_range(1) ? tone_t'($urandom_range(127)) : tone_t'($urandom_range(63, 60));
        send_note(NoteRelease, tone);
      end
    end
  endtask

  initial begin
    note_ch.valid    = 1'b0;
    note_ch.is_press = 1'b0;
    note_ch.tone     = '0;
    alloc_ch.ready   = 1'b0;
    rst_n            = 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, full table, duplicate tones, tone 0 against free voices
    set_idling(12, 12);
    send_note(NoteRelease, 7'd0);    // free voices hold tone 0 but must not match
    send_note(NoteRelease, 7'd127);  // nothing running, refused
    send_note(NotePress, 7'd0);
    send_note(NotePress, 7'd127);
    send_note(NotePress, 7'd5);
    send_note(NotePress, 7'd5);
    send_note(NotePress, 7'd42);     // no free voice, refused
    send_note(NoteRelease, 7'd5);    // lowest of the two voices with tone 5
    send_note(NoteRelease, 7'd5);
    send_note(NoteRelease, 7'd5);    // no match left
    send_note(NoteRelease, 7'd0);    // running voice with tone 0 does match
    send_note(NoteRelease, 7'd0);
    send_note(NotePress, 7'd1);      // refills the lowest free voice
    send_note(NotePress, 7'd126);
    send_note(NotePress, 7'd85);
    send_note(NotePress, 7'd42);     // table is already full again, refused
    send_note(NotePress, 7'd64);
    send_note(NoteRelease, 7'd127);
    send_note(NoteRelease, 7'd126);
    send_note(NoteRelease, 7'd1);
    send_note(NoteRelease, 7'd85);
    send_note(NoteRelease, 7'd42);
    drain_allocs();

    // no idling, with one long receiver hold while requests keep coming
    set_idling(0, 0);
    hold_ask <= hold_ask + 1;
    random_notes(PhaseItems);
    drain_allocs();

    // sparse sender
    set_idling(86, 0);
    random_notes(PhaseItems);
    drain_allocs();

    // slow receiver
    set_idling(0, 86);
    random_notes(PhaseItems);
    drain_allocs();

    // light idling on both sides
    set_idling(12, 12);
    random_notes(PhaseItems);
    drain_allocs();

    // catch any stray result after the last expected one
    set_idling(0, 0);
    repeat (SettleCycles) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** motor_voice_allocator_unit: PASSED **");
    end else begin
      $display("** motor_voice_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule
